@@ src/qdml_pkg.sv @@
// Shared types, codes and phase map for the quadrature decoder with miss lock.
package qdml_pkg;

	localparam int MissWidth = 16;
	localparam int PosWidth  = 32;

	localparam logic [1:0] STEP_NONE    = 2'd0;
	localparam logic [1:0] STEP_FWD     = 2'd1;
	localparam logic [1:0] STEP_BACK    = 2'd2;
	localparam logic [1:0] STEP_ILLEGAL = 2'd3;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic [MissWidth-1:0] MISS_MAX = '1;

	typedef struct packed {
		logic [1:0]           last_phase;
		logic                 primed;
		logic [PosWidth-1:0]  rotation;
		logic [MissWidth-1:0] miss;
		logic                 lost;
	} qdml_state_t;

	// Gray order 00,01,11,10 -> 0,1,2,3
	function automatic logic [1:0] phase_of(input logic a, input logic b);
		logic [1:0] ph;
		unique case ({a, b})
			2'b00: ph = 2'd0;
			2'b01: ph = 2'd1;
			2'b11: ph = 2'd2;
			2'b10: ph = 2'd3;
			default: ph = 2'd0;
		endcase
		return ph;
	endfunction

endpackage

@@ src/qdml_core.sv @@
// Next-state and step classification for one decoder word.
module qdml_core
	import qdml_pkg::*;
(
	input  qdml_state_t          cur,
	input  logic                 kind,
	input  logic                 signal_a,
	input  logic                 signal_b,
	input  logic [MissWidth-1:0] allowed,
	output qdml_state_t          nxt,
	output logic [1:0]           step
);

	logic [1:0]           ph;
	logic [1:0]           ph_fwd;
	logic [1:0]           ph_back;
	logic [MissWidth-1:0] miss_new;

	assign ph      = phase_of(signal_a, signal_b);
	assign ph_fwd  = cur.last_phase + 2'd1;
	assign ph_back = cur.last_phase - 2'd1;

	always_comb begin
		nxt      = cur;
		step     = STEP_NONE;
		miss_new = cur.miss;
		if (kind == KIND_CLEAR) begin
			nxt.lost = 1'b0;
		end else if (!cur.lost) begin
			if (!cur.primed) begin
				nxt.primed     = 1'b1;
				nxt.last_phase = ph;
			end else if (ph != cur.last_phase) begin
				if (ph == ph_fwd) begin
					nxt.rotation = cur.rotation + PosWidth'(1);
					miss_new     = '0;
					step         = STEP_FWD;
				end else if (ph == ph_back) begin
					nxt.rotation = cur.rotation - PosWidth'(1);
					miss_new     = '0;
					step         = STEP_BACK;
				end else begin
					if (cur.miss != MISS_MAX)
						miss_new = cur.miss + MissWidth'(1);
					step = STEP_ILLEGAL;
				end
				nxt.miss       = miss_new;
				nxt.lost       = (miss_new > allowed);
				nxt.last_phase = ph;
			end
		end
	end

endmodule

@@ src/quadrature_decoder_with_miss_lock.sv @@
// Top level: x4 quadrature decoder with miss counter and sticky lost-track lock.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | kind, signal_a, signal_b
//  out     | output    | out_valid / out_ready| position, step, lost_track
//  cfg     | input     | cfg_we (no wait)     | cfg_wdata -> allowed_misses
//
//  One word per cycle unless out_ready stalls; out_valid is the result valid.
//  Input register, then decode and state update into the result register.
//  A stalled result register holds; the input register still takes one word.
//  arst_n clears state, allowed_misses and both valid flags.
module quadrature_decoder_with_miss_lock
	import qdml_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic                 signal_a,
	input  logic                 signal_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PosWidth-1:0]  position,
	output logic [1:0]           step,
	output logic                 lost_track,
	input  logic                 cfg_we,
	input  logic [MissWidth-1:0] cfg_wdata
);

	logic                 valid_s1;
	logic                 kind_s1;
	logic                 a_s1;
	logic                 b_s1;
	logic                 valid_s2;
	logic [PosWidth-1:0]  position_s2;
	logic [1:0]           step_s2;
	logic                 lost_s2;
	logic [MissWidth-1:0] allowed_q;
	qdml_state_t          state_q;
	qdml_state_t          state_nxt;
	logic [1:0]           step_nxt;
	logic                 adv_s2;

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	qdml_core u_core (
		.cur      (state_q),
		.kind     (kind_s1),
		.signal_a (a_s1),
		.signal_b (b_s1),
		.allowed  (allowed_q),
		.nxt      (state_nxt),
		.step     (step_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= '0;
		end else if (cfg_we) begin
			allowed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s2) begin
				valid_s2 <= valid_s1;
				if (valid_s1)
					state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			a_s1    <= signal_a;
			b_s1    <= signal_b;
		end
		if (adv_s2 && valid_s1) begin
			position_s2 <= state_nxt.rotation;
			step_s2     <= step_nxt;
			lost_s2     <= state_nxt.lost;
		end
	end

	assign out_valid  = valid_s2;
	assign position   = position_s2;
	assign step       = step_s2;
	assign lost_track = lost_s2;

endmodule

@@ src/qdml_chk.sv @@
// Port-level checker for the quadrature decoder, bound to the top level.
module qdml_chk
	import qdml_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [PosWidth-1:0] position,
	input logic [1:0]          step,
	input logic                lost_track
);

	logic                seen_q;
	logic [PosWidth-1:0] last_pos_q;
	logic                out_acc;

	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_pos_q <= '0;
		end else if (out_acc) begin
			seen_q     <= 1'b1;
			last_pos_q <= position;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(step)
			&& $stable(lost_track))
		else $error("result word changed while stalled");

	a_step_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (step == STEP_FWD || step == STEP_BACK) |-> !lost_track)
		else $error("valid step reported with lost-track set");

	a_pos_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q && step == STEP_FWD |-> position == last_pos_q + PosWidth'(1))
		else $error("forward step did not advance position by one");

	a_pos_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q && step == STEP_BACK |-> position == last_pos_q - PosWidth'(1))
		else $error("backward step did not retreat position by one");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (step == STEP_NONE || step == STEP_ILLEGAL) |-> position == last_pos_q)
		else $error("position moved without a valid step");

endmodule

bind quadrature_decoder_with_miss_lock qdml_chk u_qdml_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.position   (position),
	.step       (step),
	.lost_track (lost_track)
);
